@@ hw/rtl/isl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isl_pkg
// Shared constants and codes for the indexed sequence list.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND  = 3'd0,
    FUNC_PREPEND = 3'd1,
    FUNC_POP     = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_WRITE   = 3'd4,
    FUNC_INSERT  = 3'd5,
    FUNC_REMOVE  = 3'd6
  } func_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_INDEX = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/isl_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isl_store
// Element memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module isl_store #(
  parameter int unsigned CAPACITY   = isl_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire                  clk_i,
  input  isl_pkg::mem_ctl_t    ctl_i,
  input  wire [AW-1:0]         waddr_i,
  input  wire [DATA_WIDTH-1:0] wdata_i,
  input  wire [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/isl_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isl_seq
// Command decode and sequencer: moves one element at a time, a read then a
// write, through the store's single port pair, then posts the result word.
// ----------------------------------------------------------------------------
module isl_seq #(
  parameter int unsigned CAPACITY   = isl_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [isl_pkg::FUNC_W-1:0]   in_func_i,
  input  wire [isl_pkg::VAL_W-1:0]    in_value_i,
  input  wire [isl_pkg::POS_W-1:0]    in_pos_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [isl_pkg::VAL_W-1:0]   out_read_value_o,
  output logic [isl_pkg::ST_W-1:0]    out_status_o,
  output logic [isl_pkg::CNT_W-1:0]   out_count_o,
  output isl_pkg::mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [DATA_WIDTH-1:0]       mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  wire [DATA_WIDTH-1:0]        mem_rdata_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;
  localparam int unsigned XW = (DATA_WIDTH > isl_pkg::VAL_W) ? DATA_WIDTH : isl_pkg::VAL_W;
  localparam int unsigned CX = (CW > isl_pkg::CNT_W) ? CW : isl_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD_AT  = 7'b0000010,
    S_RD_CAP = 7'b0000100,
    S_SH_RD  = 7'b0001000,
    S_SH_WR  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_OPEN  = 3'd3,
    ACT_CLOSE = 3'd4
  } act_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;

  act_e                   act_q, dec_act;
  isl_pkg::status_e       st_q, dec_st;
  logic [AW-1:0]          at_q, dec_at;
  logic [AW-1:0]          dst_q, dec_dst, src;
  logic [CW-1:0]          left_q, dec_left;
  logic [DATA_WIDTH-1:0]  val_q, rdv_q;

  logic [isl_pkg::VAL_W-1:0] rv_out_q;
  logic [isl_pkg::ST_W-1:0]  st_out_q;
  logic [isl_pkg::CNT_W-1:0] cnt_out_q;

  logic                   in_acc, out_load, full;
  logic [PW-1:0]          pos_x, cnt_x;
  logic [AW-1:0]          count_lo;
  logic [XW-1:0]          val_x, rdv_x;
  logic [CX-1:0]          cnt_xx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  assign full     = (count_q == CW'(CAPACITY));
  assign pos_x    = PW'(in_pos_i);
  assign cnt_x    = PW'(count_q);
  assign count_lo = count_q[AW-1:0];
  assign val_x    = XW'(in_value_i);
  assign rdv_x    = XW'(rdv_q);
  assign cnt_xx   = CX'(count_q);

  // decode against the count before the command
  always_comb begin
    dec_act = ACT_NONE;
    dec_st  = isl_pkg::ST_OK;
    dec_at  = '0;
    case (in_func_i)
      isl_pkg::FUNC_APPEND: begin
        if (full) dec_st = isl_pkg::ST_FULL;
        else begin
          dec_act = ACT_OPEN;
          dec_at  = count_lo;
        end
      end
      isl_pkg::FUNC_PREPEND: begin
        if (full) dec_st = isl_pkg::ST_FULL;
        else dec_act = ACT_OPEN;
      end
      isl_pkg::FUNC_POP: begin
        if (count_q == '0) dec_st = isl_pkg::ST_EMPTY;
        else dec_act = ACT_CLOSE;
      end
      isl_pkg::FUNC_READ: begin
        if (pos_x >= cnt_x) dec_st = isl_pkg::ST_INDEX;
        else begin
          dec_act = ACT_READ;
          dec_at  = pos_x[AW-1:0];
        end
      end
      isl_pkg::FUNC_WRITE: begin
        if (pos_x > cnt_x) dec_st = isl_pkg::ST_INDEX;
        else if (pos_x < cnt_x) begin
          dec_act = ACT_WRITE;
          dec_at  = pos_x[AW-1:0];
        end else if (full) dec_st = isl_pkg::ST_FULL;
        else begin
          dec_act = ACT_OPEN;
          dec_at  = count_lo;
        end
      end
      isl_pkg::FUNC_INSERT: begin
        if (pos_x > cnt_x) dec_st = isl_pkg::ST_INDEX;
        else if (full) dec_st = isl_pkg::ST_FULL;
        else begin
          dec_act = ACT_OPEN;
          dec_at  = pos_x[AW-1:0];
        end
      end
      isl_pkg::FUNC_REMOVE: begin
        if (pos_x >= cnt_x) dec_st = isl_pkg::ST_INDEX;
        else begin
          dec_act = ACT_CLOSE;
          dec_at  = pos_x[AW-1:0];
        end
      end
      default: begin
        dec_act = ACT_NONE;
      end
    endcase
  end

  // moves needed: open shifts count-at words up, close shifts count-1-at down
  assign dec_left = (dec_act == ACT_OPEN)  ? (count_q - CW'(dec_at)) :
                    (dec_act == ACT_CLOSE) ? (count_q - CW'(dec_at) - CW'(1)) : '0;
  assign dec_dst  = (dec_act == ACT_OPEN) ? count_lo : dec_at;

  // shared address step
  assign src = (act_q == ACT_OPEN) ? (dst_q - AW'(1)) : (dst_q + AW'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (dec_act)
            ACT_NONE:  state_d = S_FINISH;
            ACT_READ:  state_d = S_RD_AT;
            ACT_CLOSE: state_d = S_RD_AT;
            ACT_WRITE: state_d = S_FILL;
            ACT_OPEN:  state_d = (dec_left == '0) ? S_FILL : S_SH_RD;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_RD_AT: state_d = S_RD_CAP;
      S_RD_CAP: begin
        if (act_q == ACT_CLOSE && left_q != '0) state_d = S_SH_RD;
        else begin
          state_d = S_FINISH;
          if (act_q == ACT_CLOSE) count_d = count_q - CW'(1);
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: begin
        if (left_q == CW'(1)) begin
          if (act_q == ACT_OPEN) state_d = S_FILL;
          else begin
            state_d = S_FINISH;
            count_d = count_q - CW'(1);
          end
        end else state_d = S_SH_RD;
      end
      S_FILL: begin
        state_d = S_FINISH;
        if (act_q == ACT_OPEN) count_d = count_q + CW'(1);
      end
      S_FINISH: begin
        if (out_load) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= dec_act;
      st_q   <= dec_st;
      at_q   <= dec_at;
      dst_q  <= dec_dst;
      left_q <= dec_left;
      val_q  <= val_x[DATA_WIDTH-1:0];
      rdv_q  <= '0;
    end
    if (state_q == S_RD_CAP) rdv_q <= mem_rdata_i;
    if (state_q == S_SH_WR) begin
      dst_q  <= src;
      left_q <= left_q - CW'(1);
    end
    if (out_load) begin
      rv_out_q  <= rdv_x[isl_pkg::VAL_W-1:0];
      st_out_q  <= st_q;
      cnt_out_q <= cnt_xx[isl_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    mem_ctl_o.rd_en = (state_q == S_RD_AT) || (state_q == S_SH_RD);
    mem_ctl_o.wr_en = (state_q == S_SH_WR) || (state_q == S_FILL);
    mem_raddr_o     = (state_q == S_SH_RD) ? src : at_q;
    mem_waddr_o     = (state_q == S_SH_WR) ? dst_q : at_q;
    mem_wdata_o     = (state_q == S_SH_WR) ? mem_rdata_i : val_q;
  end

  assign out_valid_o      = out_valid_q;
  assign out_read_value_o = rv_out_q;
  assign out_status_o     = st_out_q;
  assign out_count_o      = cnt_out_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("count exceeds capacity");
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.wr_en && mem_ctl_o.rd_en)) else $error("read and write together");
  a_shift_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> (left_q != '0)) else $error("shift with no moves left");
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("ready straight after accept");
  a_post_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_FINISH))
    else $error("result posted outside finish");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/indexed_sequence_list.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_list
// Ordered list of up to CAPACITY values held in a single-port-pair memory,
// shifted one word at a time by a small sequencer.
//
// Channel  Dir  tdata (low bit up)                      tuser
// s_axis   in   item_value[31:0], position[38:32]       func[2:0]
// m_axis   out  read_value[31:0], element_count[38:32]  status[1:0]
//
// Errors and unused codes finish at once; write in place fills one word;
// read fetches one; grow shifts count-index words up, then fills; pop and
// remove fetch, then shift count-1-index words down, bound by the memory's
// one read and one write port. Reset clears count and state, not the store.
// A new command is taken while the previous result word waits; the block
// holds in its last state until the output register is free.
// ----------------------------------------------------------------------------
module indexed_sequence_list #(
  parameter int unsigned CAPACITY   = isl_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire [39:0]  s_axis_tdata_i,  // item_value[31:0], position[38:32]
  input  wire [2:0]   s_axis_tuser_i,  // func[2:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // read_value[31:0], element_count[38:32]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned AW = $clog2(CAPACITY);

  isl_pkg::mem_ctl_t      mem_ctl;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]  mem_wdata, mem_rdata;
  logic [isl_pkg::VAL_W-1:0] rv;
  logic [isl_pkg::CNT_W-1:0] cnt;

  isl_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .in_func_i        (s_axis_tuser_i),
    .in_value_i       (s_axis_tdata_i[31:0]),
    .in_pos_i         (s_axis_tdata_i[38:32]),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_read_value_o (rv),
    .out_status_o     (m_axis_tuser_o),
    .out_count_o      (cnt),
    .mem_ctl_o        (mem_ctl),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  isl_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata_o = {1'b0, cnt, rv};

endmodule
`default_nettype wire
